// ===== rtl/double_free_detector_top_macros.svh =====
// Assertion macros for the double free detector.
// Used by double_free_detector_top; expects signals clock and reset in scope.
`ifndef DOUBLE_FREE_DETECTOR_TOP_MACROS_SVH
`define DOUBLE_FREE_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dfd_pkg.sv =====
// Shared types and constants for the double free detector.
// No dependencies; imported by dfd_cell and double_free_detector_top.
`default_nettype none

package dfd_pkg;

   localparam int REQ_ADDRESS_W = 64;
   localparam int COUNT_W       = 32;
   localparam int LIVE_W        = 7;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic active;
      logic command;
      logic done;
      logic skip;
   } dfd_token_type;

endpackage

`default_nettype wire

// ===== rtl/dfd_cell.sv =====
// One table entry of the detector: holds a valid bit and an address.
// Passes the event token to the next cell each cycle. Depends on dfd_pkg.
`default_nettype none

module dfd_cell
   import dfd_pkg::*;
#(
   parameter int ADDRESS_BITS = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dfd_token_type           tok_in,
   input  wire logic [ADDRESS_BITS-1:0] addr_in,
   output dfd_token_type                tok_out,
   output logic [ADDRESS_BITS-1:0]      addr_out
);

   logic                    valid_ff;
   logic                    valid_in;
   logic [ADDRESS_BITS-1:0] entry_ff;
   dfd_token_type           tok_ff;
   dfd_token_type           tok_in_next;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic                    eligible;
   logic                    hit_alloc;
   logic                    hit_free;

   assign eligible  = tok_in.active & ~tok_in.done & ~tok_in.skip;
   assign hit_alloc = eligible & (tok_in.command == CMD_ALLOC) & ~valid_ff;
   assign hit_free  = eligible & (tok_in.command == CMD_FREE) & valid_ff
                    & (entry_ff == addr_in);

   always_comb begin
      valid_in = valid_ff;
      if (hit_alloc) begin
         valid_in = 1'b1;
      end else if (hit_free) begin
         valid_in = 1'b0;
      end
      tok_in_next      = tok_in;
      tok_in_next.done = tok_in.done | hit_alloc | hit_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff       <= '0;
      end else begin
         valid_ff     <= valid_in;
         tok_ff       <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (hit_alloc) begin
         entry_ff <= addr_in;
      end
   end

   assign tok_out  = tok_ff;
   assign addr_out = addr_ff;

endmodule

`default_nettype wire

// ===== rtl/double_free_detector_top.sv =====
// Each accepted event walks the cell row one cell per cycle; busy stays high until it
// leaves the last cell, and no new item is taken while busy is high.
// A new item may start in the cycle its predecessor's result is on rsp_strobe.
// Reset clears all valid bits and counters; no sweep follows.
// Results cannot be stalled by the receiver.
`default_nettype none
`include "double_free_detector_top_macros.svh"

module double_free_detector_top
   import dfd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int ADDRESS_BITS  = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_command,
   input  wire logic [REQ_ADDRESS_W-1:0] req_address,
   output logic                          rsp_strobe,
   output logic                          rsp_freed_ok,
   output logic                          rsp_bad_free,
   output logic                          rsp_table_full,
   output logic [COUNT_W-1:0]            rsp_bad_free_count,
   output logic [LIVE_W-1:0]             rsp_live_entries
);

   dfd_token_type           tok_chain  [0:TABLE_ENTRIES];
   logic [ADDRESS_BITS-1:0] addr_chain [0:TABLE_ENTRIES];

   logic                busy_ff;
   logic                busy_in;
   logic                accept;
   logic                strobe_ff;
   logic                ok_ff;
   logic                bad_ff;
   logic                full_ff;
   logic [COUNT_W-1:0]  bad_total_ff;
   logic [COUNT_W-1:0]  bad_total_in;
   logic [LIVE_W-1:0]   live_ff;
   logic [LIVE_W-1:0]   live_in;
   dfd_token_type       tail;
   logic                tail_ok;
   logic                tail_bad;
   logic                tail_full;
   logic                tail_added;

   assign accept = start & ~busy_ff;

   always_comb begin
      tok_chain[0].active  = accept;
      tok_chain[0].command = req_command;
      tok_chain[0].done    = 1'b0;
      tok_chain[0].skip    = (req_address[ADDRESS_BITS-1:0] == '0);
      addr_chain[0]        = req_address[ADDRESS_BITS-1:0];
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      dfd_cell #(
         .ADDRESS_BITS (ADDRESS_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_chain[i]),
         .addr_in  (addr_chain[i]),
         .tok_out  (tok_chain[i+1]),
         .addr_out (addr_chain[i+1])
      );
   end

   assign tail       = tok_chain[TABLE_ENTRIES];
   assign tail_ok    = (tail.command == CMD_FREE) & tail.done;
   assign tail_bad   = (tail.command == CMD_FREE) & ~tail.done & ~tail.skip;
   assign tail_full  = (tail.command == CMD_ALLOC) & ~tail.done & ~tail.skip;
   assign tail_added = (tail.command == CMD_ALLOC) & tail.done;

   always_comb begin
      busy_in      = busy_ff;
      bad_total_in = bad_total_ff;
      live_in      = live_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (tail.active) begin
         busy_in = 1'b0;
         if (tail_bad && (bad_total_ff != COUNT_MAX)) begin
            bad_total_in = bad_total_ff + 1'b1;
         end
         if (tail_added) begin
            live_in = live_ff + 1'b1;
         end else if (tail_ok) begin
            live_in = live_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         strobe_ff    <= 1'b0;
         bad_total_ff <= '0;
         live_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         strobe_ff    <= tail.active;
         bad_total_ff <= bad_total_in;
         live_ff      <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= tail_ok;
      bad_ff  <= tail_bad;
      full_ff <= tail_full;
   end

   assign busy               = busy_ff;
   assign rsp_strobe         = strobe_ff;
   assign rsp_freed_ok       = ok_ff;
   assign rsp_bad_free       = bad_ff;
   assign rsp_table_full     = full_ff;
   assign rsp_bad_free_count = bad_total_ff;
   assign rsp_live_entries   = live_ff;

   `DFD_ASSERT_NOW(a_one_flag, strobe_ff, $countones({ok_ff, bad_ff, full_ff}) <= 1, "more than one result flag set")
   `DFD_ASSERT_NEXT(a_accept_busy, accept, busy_ff, "busy not raised after accept")
   `DFD_ASSERT_NOW(a_strobe_idle, strobe_ff, !busy_ff, "result shown while still busy")
   `DFD_ASSERT_NEXT(a_count_mono, 1'b1, bad_total_ff >= $past(bad_total_ff), "bad free count decreased")
   `DFD_ASSERT_NOW(a_live_bound, 1'b1, (TABLE_ENTRIES > 127) || (live_ff <= TABLE_ENTRIES), "live count above table size")

endmodule

`default_nettype wire
